@@ hw/rtl/oli_pkg.sv @@
// shared types and constants for the ordered list block
`default_nettype none

package oli_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int FOUND_W = 5;
    localparam int CNT_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_GET    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SEARCH = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_TAKE,
        S_REM,
        S_REM_WR,
        S_SRCH,
        S_SCMP,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [VAL_W-1:0]     read_value;
        logic [FOUND_W-1:0]   found_position;
        logic [CNT_W-1:0]     item_count;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/ordered_list_insert_remove_top.sv @@
// top level of the fixed-capacity ordered list with insert and remove
//
// requests arrive on the s_axis channel: tuser carries the command (append,
// insert, get, remove, search, clear), tdata the position and the item value.
// each request gives exactly one result on the m_axis channel: tuser carries
// the status (ok, index out of range, list full), tdata the read value, the
// last matching position of a search (-1 if none) and the item count.
// one request is worked at a time; s_axis_tready is high only while the
// sequencer is idle. the entry memory has one write and one registered read
// port; every shifted entry is read and then written back one place over,
// and every searched entry is read and then compared with the item value.
// reset empties the list (count zero); no clearing pass is needed since only
// entries below the count are used. a result waits in the output register
// while m_axis_tready is low; the next request is still taken and worked, and
// its result is held in the sequencer until the output register is free.
`default_nettype none

module ordered_list_insert_remove_top
    import oli_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int ITEM_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[4:0], item_value[36:5], zero pad
    input  wire logic [2:0]  s_axis_tuser,   // command[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // read_value[31:0], found_position[36:32],
                                             // item_count[41:37], zero pad
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(LIST_DEPTH);

    // sequencer to memory
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ITEM_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ITEM_BITS-1:0] rd_data;

    // sequencer to output register
    logic                 done;
    logic                 out_free;
    t_result              result;

    logic                 r_out_valid;
    t_result              r_out;

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || m_axis_tready;

    oli_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .ITEM_BITS  (ITEM_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_pos       (s_axis_tdata[4:0]),
        .i_value     (s_axis_tdata[36:5]),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_result    (result),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    oli_store #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (ITEM_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register: valid is control, payload loads with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {6'b0, r_out.item_count, r_out.found_position, r_out.read_value};

endmodule

`default_nettype wire

@@ hw/rtl/oli_store.sv @@
// entry memory: one write port, one registered read port
`default_nettype none

module oli_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/oli_seq.sv @@
// command sequencer: range checks, shift loops and search over the entry memory
`default_nettype none

module oli_seq
    import oli_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int ITEM_BITS  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic [CMD_W-1:0]              i_cmd,
    input  wire logic [POS_W-1:0]              i_pos,
    input  wire logic [VAL_W-1:0]              i_value,
    input  wire logic                          i_out_free,
    output logic                               o_done,
    output t_result                            o_result,
    output logic                               o_wr_en,
    output logic [$clog2(LIST_DEPTH)-1:0]      o_wr_addr,
    output logic [ITEM_BITS-1:0]               o_wr_data,
    output logic                               o_rd_en,
    output logic [$clog2(LIST_DEPTH)-1:0]      o_rd_addr,
    input  wire logic [ITEM_BITS-1:0]          i_rd_data
);

    localparam int AW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int XW   = (CW > POS_W) ? CW : POS_W;
    localparam int WIDE = (ITEM_BITS > VAL_W) ? ITEM_BITS : VAL_W;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    t_status               r_status, n_status;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_found, n_found;
    logic                  r_hit, n_hit;
    logic [ITEM_BITS-1:0]  r_val, n_val;
    logic [ITEM_BITS-1:0]  r_read, n_read;

    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         found_x;
    logic [WIDE-1:0]       in_wide;
    logic [WIDE-1:0]       read_wide;
    logic [ITEM_BITS-1:0]  in_item;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;
    logic                  full;

    assign pos_x     = XW'(i_pos);
    assign cnt_x     = XW'(r_count);
    assign found_x   = XW'(r_found);
    assign in_wide   = WIDE'(i_value);
    assign in_item   = in_wide[ITEM_BITS-1:0];
    assign read_wide = WIDE'(r_read);
    // the shared index unit
    assign idx_inc   = r_idx + CW'(1);
    assign idx_dec   = r_idx - CW'(1);
    assign full      = (r_count == CW'(LIST_DEPTH));

    assign o_req_ready = (r_state == S_IDLE);

    assign o_result.status         = r_status;
    assign o_result.read_value     = read_wide[VAL_W-1:0];
    assign o_result.found_position = r_hit ? found_x[FOUND_W-1:0] : '1;
    assign o_result.item_count     = cnt_x[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_hit    <= n_hit;
        r_val    <= n_val;
        r_read   <= n_read;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_status  = r_status;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_hit     = r_hit;
        n_val     = r_val;
        n_read    = r_read;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx[AW-1:0];
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[AW-1:0];
        o_done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd     = t_cmd'(i_cmd);
                    n_pos     = pos_x[CW-1:0];
                    n_val     = in_item;
                    n_status  = ST_OK;
                    n_read    = '0;
                    n_hit     = 1'b0;
                    n_state   = S_FIN;
                    // speculative read for get and remove
                    o_rd_en   = 1'b1;
                    o_rd_addr = pos_x[AW-1:0];
                    case (t_cmd'(i_cmd))
                        CMD_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[AW-1:0];
                                o_wr_data = in_item;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CMD_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS;
                            end
                        end
                        CMD_GET, CMD_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_TAKE;
                            end
                        end
                        CMD_SEARCH: begin
                            n_idx   = '0;
                            n_state = S_SRCH;
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_idx > r_pos) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = idx_dec[AW-1:0];
                    n_state   = S_INS_WR;
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos[AW-1:0];
                    o_wr_data = r_val;
                    n_count   = r_count + CW'(1);
                    n_state   = S_FIN;
                end
            end
            S_INS_WR: begin
                o_wr_en = 1'b1;
                n_idx   = idx_dec;
                n_state = S_INS;
            end
            S_TAKE: begin
                n_read = i_rd_data;
                if (r_cmd == CMD_REMOVE) begin
                    n_idx   = r_pos;
                    n_state = S_REM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_REM: begin
                if (idx_inc < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = idx_inc[AW-1:0];
                    n_state   = S_REM_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_REM_WR: begin
                o_wr_en = 1'b1;
                n_idx   = idx_inc;
                n_state = S_REM;
            end
            S_SRCH: begin
                if (r_idx < r_count) begin
                    o_rd_en = 1'b1;
                    n_state = S_SCMP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCMP: begin
                // later matches overwrite earlier ones
                if (i_rd_data == r_val) begin
                    n_hit   = 1'b1;
                    n_found = r_idx;
                end
                n_idx   = idx_inc;
                n_state = S_SRCH;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid) |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after taking a request");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> full)
        else $error("full status reported with room left");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (32'(o_wr_addr) < LIST_DEPTH))
        else $error("memory write beyond list depth");

endmodule

`default_nettype wire
